[rtl/assert_macros.svh]
// Assertion macros for the RTL top module.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/lkx_pkg.sv]
`timescale 1ns / 1ps

package lkx_pkg;

    // Generator constants
    localparam int KEY_W = 31;
    localparam logic [KEY_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] LCG_MUL = 31'd16807;
    localparam logic [KEY_W-1:0] KEY_RST = 31'd1;

    // Position and offset widths
    localparam int POS_BITS = 32;
    localparam int OFS_W    = 32;
    localparam int EXP_W    = POS_BITS - 1;
    localparam int TGT_W    = ((POS_BITS > OFS_W) ? POS_BITS : OFS_W) + 2;
    localparam int PROD_W   = 2 * KEY_W;

    // Item kinds on the input tuser
    localparam logic MODE_CRYPT = 1'b0;
    localparam logic MODE_SEEK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_WB
    } t_state;

    // Modular multiply operations of the shared unit
    typedef enum logic [1:0] {
        OP_STEP,    // key  * 16807 -> key
        OP_ACC,     // acc  * base  -> acc
        OP_SQR,     // base * base  -> base, exponent shifts right
        OP_FINAL    // seed * acc   -> key
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic s_ready;
        logic cfg_ready;
        logic accept;
        logic cfg_we;
        logic mul;
        logic wb;
        t_op  op;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic mode;
        logic pos_odd;
        logic seek_go;
        logic exp_zero;
        logic exp_lsb;
    } t_stat;

endpackage

[rtl/lkx_modmul.sv]
`timescale 1ns / 1ps

module lkx_modmul
    import lkx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [KEY_W-1:0] i_a,
    input  logic [KEY_W-1:0] i_b,
    output logic [KEY_W-1:0] o_res
);

    logic [PROD_W-1:0] r_prod;
    logic [KEY_W:0]    w_sum;
    logic [KEY_W:0]    w_sub;

    // Product register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    // Mod 2^31-1: fold high half onto low half, one conditional subtract
    assign w_sum = {1'b0, r_prod[PROD_W-1:KEY_W]} + {1'b0, r_prod[KEY_W-1:0]};
    assign w_sub = w_sum - {1'b0, LCG_MOD};
    assign o_res = (w_sum >= {1'b0, LCG_MOD}) ? w_sub[KEY_W-1:0] : w_sum[KEY_W-1:0];

endmodule

[rtl/lkx_dp.sv]
`timescale 1ns / 1ps

module lkx_dp
    import lkx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic             i_s_tuser,
    input  logic [39:0]      i_s_tdata,
    input  logic [KEY_W-1:0] i_cfg_data,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tuser
);

    logic [KEY_W-1:0]    r_seed;
    logic [KEY_W-1:0]    r_key;
    logic [POS_BITS-1:0] r_pos;
    logic [KEY_W-1:0]    r_acc;
    logic [KEY_W-1:0]    r_base;
    logic [EXP_W-1:0]    r_exp;
    logic                r_out_valid;
    logic [7:0]          r_out_data;
    logic                r_out_err;
    logic                n_out_valid;

    logic [7:0]          w_data_in;
    logic [OFS_W-1:0]    w_ofs;
    logic [TGT_W-1:0]    w_target;
    logic                w_range_err;
    logic                w_ofs_zero;
    logic [7:0]          w_ks;
    logic [KEY_W-1:0]    w_op_a;
    logic [KEY_W-1:0]    w_op_b;
    logic [KEY_W-1:0]    w_mm_res;

    assign w_data_in = i_s_tdata[7:0];
    assign w_ofs     = i_s_tdata[39:8];
    assign w_ofs_zero = (w_ofs == '0);

    // Seek target: position plus sign-extended offset, checked against range
    assign w_target = {{(TGT_W-POS_BITS){1'b0}}, r_pos}
                    + {{(TGT_W-OFS_W){w_ofs[OFS_W-1]}}, w_ofs};
    assign w_range_err = w_target[TGT_W-1] | (|w_target[TGT_W-2:POS_BITS]);

    // Keystream byte by position parity
    assign w_ks = r_pos[0] ? r_key[22:15] : r_key[30:23];

    // Operand select for the shared modular multiplier
    always_comb begin
        case (i_cmd.op)
            OP_STEP: begin
                w_op_a = r_key;
                w_op_b = LCG_MUL;
            end
            OP_ACC: begin
                w_op_a = r_acc;
                w_op_b = r_base;
            end
            OP_SQR: begin
                w_op_a = r_base;
                w_op_b = r_base;
            end
            OP_FINAL: begin
                w_op_a = r_seed;
                w_op_b = r_acc;
            end
            default: begin
                w_op_a = r_key;
                w_op_b = LCG_MUL;
            end
        endcase
    end

    lkx_modmul u_modmul (
        .i_clk  (i_clk),
        .i_load (i_cmd.mul),
        .i_a    (w_op_a),
        .i_b    (w_op_b),
        .o_res  (w_mm_res)
    );

    // Seed, running key and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= KEY_RST;
            r_key  <= KEY_RST;
            r_pos  <= '0;
        end else if (i_cmd.cfg_we) begin
            r_seed <= i_cfg_data;
            r_key  <= i_cfg_data;
            r_pos  <= '0;
        end else if (i_cmd.accept) begin
            if (i_s_tuser == MODE_CRYPT) begin
                r_pos <= r_pos + POS_BITS'(1);
            end else if (o_stat.seek_go) begin
                r_pos <= w_target[POS_BITS-1:0];
            end
        end else if (i_cmd.wb && (i_cmd.op == OP_STEP || i_cmd.op == OP_FINAL)) begin
            r_key <= w_mm_res;
        end
    end

    // Exponentiation registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_stat.seek_go) begin
            r_exp  <= w_target[POS_BITS-1:1];
            r_acc  <= KEY_RST;
            r_base <= LCG_MUL;
        end else if (i_cmd.wb) begin
            if (i_cmd.op == OP_ACC) begin
                r_acc <= w_mm_res;
            end else if (i_cmd.op == OP_SQR) begin
                r_base <= w_mm_res;
                r_exp  <= r_exp >> 1;
            end
        end
    end

    // Output register: loaded at input transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.accept) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (i_s_tuser == MODE_CRYPT) begin
                r_out_data <= w_data_in ^ w_ks;
                r_out_err  <= 1'b0;
            end else begin
                r_out_data <= 8'h00;
                r_out_err  <= ~w_ofs_zero & w_range_err;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_err;

    // Status to controller
    assign o_stat.out_free = ~r_out_valid | i_m_tready;
    assign o_stat.mode     = i_s_tuser;
    assign o_stat.pos_odd  = r_pos[0];
    assign o_stat.seek_go  = (i_s_tuser == MODE_SEEK) & ~w_ofs_zero & ~w_range_err;
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_lsb  = r_exp[0];

endmodule

[rtl/lkx_ctrl.sv]
`timescale 1ns / 1ps

module lkx_ctrl
    import lkx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  logic  i_cfg_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    t_op    r_op;
    t_op    n_op;

    // State and operation registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_STEP;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        o_cmd.s_ready   = 1'b0;
        o_cmd.cfg_ready = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.cfg_we    = 1'b0;
        o_cmd.mul       = 1'b0;
        o_cmd.wb        = 1'b0;
        o_cmd.op        = r_op;
        case (r_state)
            ST_IDLE: begin
                // config write takes priority over an item in the same cycle
                o_cmd.cfg_ready = 1'b1;
                o_cmd.cfg_we    = i_cfg_valid;
                o_cmd.s_ready   = i_stat.out_free & ~i_cfg_valid;
                o_cmd.accept    = o_cmd.s_ready & i_s_tvalid;
                if (o_cmd.accept) begin
                    if (i_stat.mode == MODE_CRYPT) begin
                        if (i_stat.pos_odd) begin
                            n_op    = OP_STEP;
                            n_state = ST_MUL;
                        end
                    end else if (i_stat.seek_go) begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                // pick next exponent step from the remaining bits
                if (i_stat.exp_zero) begin
                    n_op = OP_FINAL;
                end else if (i_stat.exp_lsb) begin
                    n_op = OP_ACC;
                end else begin
                    n_op = OP_SQR;
                end
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_WB;
            end
            ST_WB: begin
                o_cmd.wb = 1'b1;
                case (r_op)
                    OP_ACC: begin
                        n_op    = OP_SQR;
                        n_state = ST_MUL;
                    end
                    OP_SQR: begin
                        n_state = ST_DECIDE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/lehmer_keystream_byte_xor.sv]
`timescale 1ns / 1ps
// A result is registered at the output in the cycle after its input transfer.
// An even-position byte leaves the engine idle; an odd-position byte first steps the
// key through the shared modular multiplier (MUL, then WB). A zero or refused seek
// leaves it idle; a seek that moves runs square-and-multiply over the pair count.
// Reset (synchronous, active low): start and running key 1, position 0, output empty.

`include "assert_macros.svh"

module lehmer_keystream_byte_xor
    import lkx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write: start_key
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [KEY_W-1:0] i_cfg_data,
    // input stream
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [39:0]      i_s_tdata,   // [7:0] data_in, [39:8] seek_offset
    input  logic             i_s_tuser,   // [0] mode
    // output stream
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] data_out
    output logic             o_m_tuser    // [0] seek_error
);

    t_cmd  w_cmd;
    t_stat w_stat;

    lkx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lkx_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    assign o_s_tready  = w_cmd.s_ready;
    assign o_cfg_ready = w_cmd.cfg_ready;

    // Input is taken only when the output register can hold the result
    `ASSERT_IMPL(a_in_needs_out_room, i_clk, i_rst_n, o_s_tready, !o_m_tvalid || i_m_tready)
    // Every input transfer leaves a result pending
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_s_tvalid && o_s_tready, o_m_tvalid)
    // Items are taken only while the engine is idle
    `ASSERT_IMPL(a_ready_when_idle, i_clk, i_rst_n, o_s_tready, o_cfg_ready && !i_cfg_valid)

endmodule

[tb/lehmer_keystream_byte_xor_tb.sv]
`timescale 1ns / 1ps

module lehmer_keystream_byte_xor_tb;
    import lkx_pkg::*;

    localparam int IDLE_LIMIT   = 4000;  // cycles without any input or config transfer
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 400;   // result count that starts the long sink stall
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        logic             mode;
        logic [7:0]       data;
        logic [OFS_W-1:0] ofs;
    } crypt_item_t;

    typedef struct {
        logic [7:0] data;
        logic       seek_err;
    } crypt_result_t;

    // DUT connections; the driven inputs are known from time zero
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [KEY_W-1:0] i_cfg_data  = '0;
    logic             i_s_tvalid  = 1'b0;
    logic             o_s_tready;
    logic [39:0]      i_s_tdata   = '0;    // [7:0] data_in, [39:8] seek_offset
    logic             i_s_tuser   = 1'b0;  // [0] mode
    logic             o_m_tvalid;
    logic             i_m_tready  = 1'b0;
    logic [7:0]       o_m_tdata;           // [7:0] data_out
    logic             o_m_tuser;           // [0] seek_error

    lehmer_keystream_byte_xor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stimulus and expectation queues
    crypt_item_t   pending_items_q[$];
    crypt_result_t cipher_results_q[$];
    crypt_item_t   cur_item;

    // Predictor state
    logic [KEY_W-1:0]    seed_key = KEY_RST;
    logic [KEY_W-1:0]    key_now  = KEY_RST;
    logic [POS_BITS-1:0] byte_pos = '0;

    int src_idle_pct  = 33;
    int sink_idle_pct = 33;
    int errors        = 0;
    int results_seen  = 0;
    int n_crypt       = 0;
    int n_seek        = 0;
    int n_seek_err    = 0;
    int n_key_loads   = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int quiet_cycles  = 0;

    function automatic logic [KEY_W-1:0] mod_mul(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b);
        return KEY_W'(prod % 64'(LCG_MOD));
    endfunction

    // Key after a number of generator steps from the seed (square and multiply)
    function automatic logic [KEY_W-1:0] key_after_pairs(logic [KEY_W-1:0] seed,
                                                        logic [POS_BITS-1:0] pairs);
        logic [KEY_W-1:0] acc;
        logic [KEY_W-1:0] base;
        acc  = KEY_W'(1);
        base = LCG_MUL;
        for (int i = 0; i < POS_BITS; i++) begin
            if (pairs[i])
                acc = mod_mul(acc, base);
            base = mod_mul(base, base);
        end
        // a seed equal to the modulus always collapses to zero on a rewind
        if (seed == LCG_MOD)
            return '0;
        return mod_mul(seed, acc);
    endfunction

    // Advance the predicted cipher state by one accepted item
    task automatic apply_cipher_item(crypt_item_t it);
        crypt_result_t       res;
        logic [7:0]          ks;
        logic [TGT_W-1:0]    mag;
        logic [TGT_W-1:0]    sum;
        logic [POS_BITS-1:0] target;
        res.data     = '0;
        res.seek_err = 1'b0;
        if (it.mode == MODE_CRYPT) begin
            n_crypt++;
            if (byte_pos[0]) begin
                ks      = key_now[22:15];
                key_now = mod_mul(key_now, LCG_MUL);
            end else begin
                ks = key_now[30:23];
            end
            byte_pos = byte_pos + POS_BITS'(1);
            res.data = it.data ^ ks;
        end else if (it.ofs != '0) begin
            n_seek++;
            if (it.ofs[OFS_W-1]) begin
                mag = (TGT_W'(1) << OFS_W) - TGT_W'(it.ofs);
                if (mag > TGT_W'(byte_pos))
                    res.seek_err = 1'b1;
                else
                    target = byte_pos - POS_BITS'(mag);
            end else begin
                sum = TGT_W'(it.ofs) + TGT_W'(byte_pos);
                if (sum > TGT_W'({POS_BITS{1'b1}}))
                    res.seek_err = 1'b1;
                else
                    target = POS_BITS'(sum);
            end
            if (res.seek_err) begin
                n_seek_err++;
            end else begin
                key_now  = key_after_pairs(seed_key, target >> 1);
                byte_pos = target;
            end
        end else begin
            n_seek++;
        end
        cipher_results_q.push_back(res);
    endtask

    // Input stream driver
    always @(posedge i_clk) begin : src_drv
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                apply_cipher_item(cur_item);
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_items_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_item = pending_items_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {cur_item.ofs, cur_item.data};
                    i_s_tuser  <= cur_item.mode;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and sink backpressure
    always @(posedge i_clk) begin : sink_mon
        crypt_result_t want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (cipher_results_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result data_out=%02h seek_error=%0b",
                             $time, o_m_tdata, o_m_tuser);
                end else begin
                    want = cipher_results_q.pop_front();
                    if (o_m_tdata !== want.data) begin
                        errors++;
                        $display("%0t: data_out expected %02h actual %02h",
                                 $time, want.data, o_m_tdata);
                    end
                    if (o_m_tuser !== want.seek_err) begin
                        errors++;
                        $display("%0t: seek_error expected %0b actual %0b",
                                 $time, want.seek_err, o_m_tuser);
                    end
                end
            end
            // one long stall so the block backs up into its input
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no input or config transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no input transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_crypt(logic [7:0] b);
        crypt_item_t it;
        it.mode = MODE_CRYPT;
        it.data = b;
        it.ofs  = OFS_W'($urandom);  // ignored in crypt mode
        pending_items_q.push_back(it);
    endtask

    task automatic push_seek(logic [OFS_W-1:0] ofs);
        crypt_item_t it;
        it.mode = MODE_SEEK;
        it.data = 8'($urandom);      // ignored in seek mode
        it.ofs  = ofs;
        pending_items_q.push_back(it);
    endtask

    // Mostly bytes, with seeks biased toward targets that succeed
    task automatic push_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 72) begin
            push_crypt(8'($urandom));
        end else begin
            case ($urandom_range(9))
                0:       push_seek('0);
                1, 2, 3,
                4, 5:    push_seek(OFS_W'($urandom_range(60)) - OFS_W'(20));
                6, 7:    push_seek(OFS_W'($urandom));
                8: begin
                    case ($urandom_range(3))
                        0:       push_seek(32'h7FFF_FFFF);
                        1:       push_seek(32'h8000_0000);
                        2:       push_seek(32'hFFFF_FFFF);
                        default: push_seek(32'h0000_0001);
                    endcase
                end
                default: push_seek(OFS_W'($urandom_range(1 << 20)));
            endcase
        end
    endtask

    // Pause the sender until every expected result is back
    task automatic wait_drained();
        while (pending_items_q.size() > 0 || i_s_tvalid || cipher_results_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Start key write; also rewinds the predicted stream
    task automatic load_start_key(logic [KEY_W-1:0] k);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= k;
        do @(posedge i_clk); while (!o_cfg_ready);
        seed_key = k;
        key_now  = k;
        byte_pos = '0;
        n_key_loads++;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [KEY_W-1:0] phase_key[6];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key: byte extremes, zero, negative and out-of-range seeks, wrap
        push_crypt(8'h00);
        push_crypt(8'hFF);
        push_crypt(8'hA5);
        push_crypt(8'h5A);
        push_seek('0);
        push_seek(-32'sd5);
        push_seek(-32'sd4);
        push_seek(32'h8000_0000);
        push_seek(32'h7FFF_FFFF);
        push_seek(32'h7FFF_FFFF);
        push_crypt(8'h81);
        push_seek(32'h0000_0001);
        push_crypt(8'h7E);
        push_crypt(8'h3C);
        push_seek(32'h8000_0000);
        wait_drained();

        // Seed equal to the modulus: first pair as is, then zero; rewind gives zero
        load_start_key(LCG_MOD);
        push_crypt(8'h11);
        push_crypt(8'h22);
        push_crypt(8'h33);
        push_seek(-32'sd2);
        push_crypt(8'h44);
        push_seek('0);
        wait_drained();

        // Zero seed stays zero
        load_start_key('0);
        push_crypt(8'hC3);
        push_crypt(8'h96);
        push_seek(32'd10);
        push_crypt(8'hE7);
        wait_drained();

        // Random phases, each under its own start key
        phase_key[0] = KEY_RST;
        phase_key[1] = KEY_W'($urandom);
        phase_key[2] = KEY_W'($urandom);
        phase_key[3] = LCG_MOD;
        phase_key[4] = KEY_W'($urandom);
        phase_key[5] = '0;
        for (int p = 0; p < 6; p++) begin
            // phase 2 runs with no random idling on either side, but holds the long sink stall
            src_idle_pct  = (p == 2) ? 0 : 33;
            sink_idle_pct = (p == 2) ? 0 : 33;
            load_start_key(phase_key[p]);
            for (int n = 0; n < 160; n++)
                push_random_item();
            wait_drained();
        end

        $display("Covered %0d bytes, %0d seeks (%0d refused), %0d start key loads",
                 n_crypt, n_seek, n_seek_err, n_key_loads);
        if (errors == 0 && cipher_results_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
